[rtl/srt_pkg.sv]
// Shared types and constants of the sorted region table.
// Holds action and status codes, controller states and the command/status structs.
// No dependencies.
package srt_pkg;

	localparam int MAX_REGIONS_DEF  = 64;
	localparam int ADDRESS_BITS_DEF = 48;
	localparam int SIZE_BITS_DEF    = 40;
	localparam int ALIGN_BITS       = 8;
	localparam logic [63:0] DEFAULT_START = 64'h0000_0000_0010_0000;

	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_FULL      = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic alloc;
		logic srch_rd;
		logic srch_cmp;
		logic shift_rd;
		logic shift_wr;
		logic free_done;
	} dp_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic do_search;
		logic is_free;
		logic search_active;
		logic hit;
		logic shift_more;
	} dp_stat_t;

endpackage

[rtl/srt_ctrl.sv]
// Controller of the sorted region table: sequences decode, search and compaction.
// Depends on srt_pkg.
module srt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  srt_pkg::dp_stat_t stat,
	output srt_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import srt_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (stat.do_search) state_nxt = S_SRCH_RD;
				else state_nxt = S_RESP;
			end
			S_SRCH_RD: begin
				if (stat.search_active) state_nxt = S_SRCH_CMP;
				else state_nxt = S_RESP;
			end
			S_SRCH_CMP: begin
				priority if (stat.hit && stat.is_free) state_nxt = S_SHIFT_RD;
				else if (stat.hit) state_nxt = S_RESP;
				else state_nxt = S_SRCH_RD;
			end
			S_SHIFT_RD: begin
				if (stat.shift_more) state_nxt = S_SHIFT_WR;
				else state_nxt = S_RESP;
			end
			S_SHIFT_WR: state_nxt = S_SHIFT_RD;
			S_RESP:     state_nxt = S_IDLE;
			default:    state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.load = start;
			S_DISPATCH: cmd.alloc = stat.is_alloc;
			S_SRCH_RD:  cmd.srch_rd = stat.search_active;
			S_SRCH_CMP: cmd.srch_cmp = 1'b1;
			S_SHIFT_RD: begin
				cmd.shift_rd  = stat.shift_more;
				cmd.free_done = !stat.shift_more;
			end
			S_SHIFT_WR: cmd.shift_wr = 1'b1;
			default:    cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

[rtl/srt_dp.sv]
// Datapath of the sorted region table: region memory, bump pointer, search bounds,
// result registers and the start address register. Depends on srt_pkg.
module srt_dp #(
	parameter int MAX_REGIONS  = srt_pkg::MAX_REGIONS_DEF,
	parameter int ADDRESS_BITS = srt_pkg::ADDRESS_BITS_DEF,
	parameter int SIZE_BITS    = srt_pkg::SIZE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  srt_pkg::dp_cmd_t        cmd,
	output srt_pkg::dp_stat_t       stat,
	input  logic [1:0]              action,
	input  logic [ADDRESS_BITS-1:0] address,
	input  logic [SIZE_BITS-1:0]    byte_size,
	input  logic                    cfg_we,
	input  logic [ADDRESS_BITS-1:0] cfg_data,
	output logic [ADDRESS_BITS-1:0] start_addr,
	output logic [1:0]              status,
	output logic [ADDRESS_BITS-1:0] region_base,
	output logic [SIZE_BITS-1:0]    region_offset,
	output logic [SIZE_BITS-1:0]    region_length,
	output logic [6:0]              regions_in_use
);
	import srt_pkg::*;

	localparam int IW   = $clog2(MAX_REGIONS);
	localparam int CW   = $clog2(MAX_REGIONS + 1);
	localparam int SW   = SIZE_BITS + 1;
	localparam int EW   = ((ADDRESS_BITS > SW) ? ADDRESS_BITS : SW) + 1;
	localparam int CMPW = (ADDRESS_BITS > SIZE_BITS) ? ADDRESS_BITS : SIZE_BITS;

	logic [ADDRESS_BITS-1:0] base_mem [MAX_REGIONS];
	logic [SIZE_BITS-1:0]    len_mem  [MAX_REGIONS];

	logic [CW-1:0]           count_q;
	logic [ADDRESS_BITS-1:0] nfa_q;
	logic [ADDRESS_BITS-1:0] start_q;
	logic [1:0]              act_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [SIZE_BITS-1:0]    size_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hi_q;
	logic [CW-1:0]           mid_q;
	logic [CW-1:0]           idx_q;
	logic [ADDRESS_BITS-1:0] rd_base_q;
	logic [SIZE_BITS-1:0]    rd_len_q;
	logic [1:0]              res_status_q;
	logic [ADDRESS_BITS-1:0] res_base_q;
	logic [SIZE_BITS-1:0]    res_offset_q;
	logic [SIZE_BITS-1:0]    res_length_q;

	logic [CW-1:0]           mid;
	logic [CW-1:0]           nxt_idx;
	logic [ADDRESS_BITS-1:0] bump_base;
	logic [SW-1:0]           size_up;
	logic [SW-1:0]           aligned;
	logic [EW-1:0]           alloc_end;
	logic                    size_ovf;
	logic                    space_ovf;
	logic                    alloc_ok;
	logic [1:0]              alloc_status;
	logic                    below;
	logic [ADDRESS_BITS-1:0] diff;
	logic                    beyond;
	logic                    hit;
	logic                    wr_en;
	logic [IW-1:0]           wr_idx;
	logic [ADDRESS_BITS-1:0] wr_base;
	logic [SIZE_BITS-1:0]    wr_len;
	logic [IW-1:0]           rd_idx;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign nxt_idx = idx_q + CW'(1);

	assign bump_base = (nfa_q != '0) ? nfa_q :
		((start_q != '0) ? start_q : DEFAULT_START[ADDRESS_BITS-1:0]);
	assign size_up   = SW'(size_q) + SW'(2 ** ALIGN_BITS - 1);
	assign aligned   = {size_up[SW-1:ALIGN_BITS], {ALIGN_BITS{1'b0}}};
	assign size_ovf  = (SIZE_BITS == 64) && size_up[SW-1];
	assign alloc_end = EW'(bump_base) + EW'(aligned);
	assign space_ovf = size_ovf || (alloc_end[EW-1:ADDRESS_BITS] != '0);

	always_comb begin
		alloc_ok = 1'b0;
		priority if (size_q == '0) alloc_status = ST_INVALID;
		else if (count_q >= CW'(MAX_REGIONS)) alloc_status = ST_FULL;
		else if (space_ovf) alloc_status = ST_EXHAUSTED;
		else begin
			alloc_status = ST_OK;
			alloc_ok     = 1'b1;
		end
	end

	assign below  = addr_q < rd_base_q;
	assign diff   = addr_q - rd_base_q;
	assign beyond = CMPW'(diff) >= CMPW'(rd_len_q);
	assign hit    = !below && !beyond;

	assign stat.is_alloc      = (act_q == ACT_ALLOC);
	assign stat.is_free       = (act_q == ACT_FREE);
	assign stat.do_search     = ((act_q == ACT_FREE) && (addr_q != '0)) || (act_q == ACT_LOOKUP);
	assign stat.search_active = lo_q < hi_q;
	assign stat.hit           = hit;
	assign stat.shift_more    = nxt_idx < count_q;

	assign wr_en   = (cmd.alloc && alloc_ok) || cmd.shift_wr;
	assign wr_idx  = cmd.shift_wr ? idx_q[IW-1:0] : count_q[IW-1:0];
	assign wr_base = cmd.shift_wr ? rd_base_q : bump_base;
	assign wr_len  = cmd.shift_wr ? rd_len_q : size_q;
	assign rd_idx  = cmd.shift_rd ? nxt_idx[IW-1:0] : mid[IW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_mem[wr_idx] <= wr_base;
			len_mem[wr_idx]  <= wr_len;
		end
		if (cmd.srch_rd || cmd.shift_rd) begin
			rd_base_q <= base_mem[rd_idx];
			rd_len_q  <= len_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			nfa_q   <= '0;
			start_q <= DEFAULT_START[ADDRESS_BITS-1:0];
		end else begin
			if (cfg_we) start_q <= cfg_data;
			if (cmd.alloc && alloc_ok) begin
				count_q <= count_q + CW'(1);
				nfa_q   <= alloc_end[ADDRESS_BITS-1:0];
			end
			if (cmd.free_done) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q        <= action;
			addr_q       <= address;
			size_q       <= byte_size;
			lo_q         <= '0;
			hi_q         <= count_q;
			res_status_q <= ((action == ACT_FREE) && (address == '0)) ? ST_OK : ST_INVALID;
			res_base_q   <= '0;
			res_offset_q <= '0;
			res_length_q <= '0;
		end
		if (cmd.alloc) begin
			res_status_q <= alloc_status;
			if (alloc_ok) begin
				res_base_q   <= bump_base;
				res_length_q <= size_q;
			end
		end
		if (cmd.srch_rd) mid_q <= mid;
		if (cmd.srch_cmp) begin
			priority if (below) hi_q <= mid_q;
			else if (beyond) lo_q <= mid_q + CW'(1);
			else begin
				idx_q        <= mid_q;
				res_status_q <= ST_OK;
				res_base_q   <= rd_base_q;
				res_length_q <= rd_len_q;
				if (act_q == ACT_LOOKUP) res_offset_q <= SIZE_BITS'(diff);
			end
		end
		if (cmd.shift_wr) idx_q <= nxt_idx;
	end

	assign start_addr     = start_q;
	assign status         = res_status_q;
	assign region_base    = res_base_q;
	assign region_offset  = res_offset_q;
	assign region_length  = res_length_q;
	assign regions_in_use = 7'(count_q);

endmodule

[rtl/sorted_region_table_top.sv]
// Top level of the sorted region table: APB register port, controller and datapath.
// Depends on srt_pkg, srt_ctrl, srt_dp.
//
// A request is taken when start is high and busy is low; its result appears for one cycle
// with done high and cannot be stalled. Allocate, free of address zero and unknown actions
// go from the dispatch state straight to the result state. Free and look up run a binary
// search over the region memory, each probe a registered read, then a compare, with up to
// log2(MAX_REGIONS)+1 probes; a free then compacts the table, moving each following entry
// down one place with a read state, then a write state.
module sorted_region_table_top #(
	parameter int MAX_REGIONS  = srt_pkg::MAX_REGIONS_DEF,
	parameter int ADDRESS_BITS = srt_pkg::ADDRESS_BITS_DEF,
	parameter int SIZE_BITS    = srt_pkg::SIZE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	output logic                    done,
	input  logic [1:0]              action,
	input  logic [ADDRESS_BITS-1:0] address,
	input  logic [SIZE_BITS-1:0]    byte_size,
	output logic [1:0]              status,
	output logic [ADDRESS_BITS-1:0] region_base,
	output logic [SIZE_BITS-1:0]    region_offset,
	output logic [SIZE_BITS-1:0]    region_length,
	output logic [6:0]              regions_in_use,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [63:0]             pwdata,
	output logic [63:0]             prdata,
	output logic                    pready
);
	import srt_pkg::*;

	dp_cmd_t                 cmd;
	dp_stat_t                stat;
	logic                    cfg_we;
	logic [ADDRESS_BITS-1:0] start_addr;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == 4'd0);
	assign prdata = (paddr == 4'd0) ? 64'(start_addr) : 64'd0;

	srt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	srt_dp #(
		.MAX_REGIONS  (MAX_REGIONS),
		.ADDRESS_BITS (ADDRESS_BITS),
		.SIZE_BITS    (SIZE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.address        (address),
		.byte_size      (byte_size),
		.cfg_we         (cfg_we),
		.cfg_data       (pwdata[ADDRESS_BITS-1:0]),
		.start_addr     (start_addr),
		.status         (status),
		.region_base    (region_base),
		.region_offset  (region_offset),
		.region_length  (region_length),
		.regions_in_use (regions_in_use)
	);

`ifndef SYNTH
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after result");
	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("request not taken");
	a_fail_zero_base: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (region_base == '0 && region_length == '0))
		else $error("failed request reports a region");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sorted_region_table_top: random and directed allocate,
// free and look-up requests, APB writes of start_address, results checked against a
// table predictor kept in this file. Depends on srt_pkg and the RTL of the block.
module tb_top;
	import srt_pkg::*;

	localparam int NREG = 64;
	localparam logic [63:0] AMASK = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] SZMAX = 64'h0000_00FF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [3:0] REG_START = 4'd0;
	localparam logic [3:0] REG_UNUSED = 4'd8;

	typedef struct {
		action_t     act;
		logic [47:0] addr;
		logic [39:0] size;
	} request_t;

	typedef struct {
		status_t     st;
		logic [47:0] base;
		logic [39:0] off;
		logic [39:0] len;
		logic [6:0]  cnt;
	} region_result_t;

	logic clk, arst_n, start, busy, done;
	logic [1:0] action, status;
	logic [47:0] address, region_base;
	logic [39:0] byte_size, region_offset, region_length;
	logic [6:0] regions_in_use;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [63:0] pwdata, prdata;

	// side 0 follows the generator, side 1 follows accepted requests
	logic [63:0] tbl_start [2];
	logic [63:0] tbl_next [2];
	int          tbl_count [2];
	logic [63:0] tbl_base [2][NREG];
	logic [63:0] tbl_len [2][NREG];

	request_t       pending_q[$];
	region_result_t expected_q[$];
	int errors = 0, cycles = 0, gap_left = 0, requests = 0;
	int n_alloc = 0, n_full = 0, n_exh = 0, n_free = 0, n_hit = 0;
	bit taken = 0, calm = 0, quiet = 0;

	sorted_region_table_top u_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic void predict_region_op(input int s, input request_t r,
			output region_result_t e);
		logic [63:0] b, aligned, a;
		int idx, pos, i;
		e.st = ST_INVALID; e.base = '0; e.off = '0; e.len = '0;
		a = {16'h0, r.addr};
		idx = -1;
		for (i = 0; i < tbl_count[s]; i++)
			if (a >= tbl_base[s][i] && a - tbl_base[s][i] < tbl_len[s][i]) idx = i;
		case (r.act)
			ACT_ALLOC: begin
				if (r.size == 0) e.st = ST_INVALID;
				else if (tbl_count[s] >= NREG) e.st = ST_FULL;
				else begin
					b = tbl_next[s];
					if (b == 0) b = (tbl_start[s] != 0) ? tbl_start[s] : (DEFAULT_START & AMASK);
					aligned = ({24'h0, r.size} + 64'd255) & ~64'd255;
					if (b > AMASK || aligned > AMASK - b) e.st = ST_EXHAUSTED;
					else begin
						pos = tbl_count[s];
						for (i = tbl_count[s] - 1; i >= 0; i--)
							if (tbl_base[s][i] >= b) pos = i;
						for (i = tbl_count[s]; i > pos; i--) begin
							tbl_base[s][i] = tbl_base[s][i-1];
							tbl_len[s][i] = tbl_len[s][i-1];
						end
						tbl_base[s][pos] = b;
						tbl_len[s][pos] = {24'h0, r.size};
						tbl_count[s]++;
						tbl_next[s] = b + aligned;
						e.st = ST_OK; e.base = b[47:0]; e.len = r.size;
					end
				end
			end
			ACT_FREE: begin
				if (a == 0) e.st = ST_OK;
				else if (idx >= 0) begin
					e.st = ST_OK;
					e.base = tbl_base[s][idx][47:0];
					e.len = tbl_len[s][idx][39:0];
					for (i = idx; i + 1 < tbl_count[s]; i++) begin
						tbl_base[s][i] = tbl_base[s][i+1];
						tbl_len[s][i] = tbl_len[s][i+1];
					end
					tbl_count[s]--;
				end
			end
			ACT_LOOKUP: begin
				if (idx >= 0) begin
					e.st = ST_OK;
					e.base = tbl_base[s][idx][47:0];
					e.len = tbl_len[s][idx][39:0];
					e.off = 40'(a - tbl_base[s][idx]);
				end
			end
			default: e.st = ST_INVALID;
		endcase
		e.cnt = 7'(tbl_count[s]);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h (request %0d)", what, got, want, requests);
		errors++;
	endtask

	task automatic push_request(input action_t act, input logic [47:0] a,
			input logic [39:0] sz);
		request_t r;
		region_result_t e;
		r.act = act; r.addr = a; r.size = sz;
		predict_region_op(0, r, e);
		pending_q.push_back(r);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_q.size() != 0 || start || busy || expected_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic [3:0] a, input logic wr, input logic [63:0] d,
			output logic [63:0] rd);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= wr; paddr <= a; pwdata <= d;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic write_start(input logic [63:0] v);
		logic [63:0] rd;
		apb_access(REG_START, 1'b1, v, rd);
		tbl_start[0] = v & AMASK;
		tbl_start[1] = v & AMASK;
		apb_access(REG_START, 1'b0, '0, rd);
		if ((rd & AMASK) != (v & AMASK)) report_mismatch("start_address read", rd & AMASK,
			v & AMASK);
	endtask

	function automatic logic [47:0] pick_address();
		logic [63:0] off;
		int k, sel;
		sel = $urandom_range(0, 99);
		if (tbl_count[0] == 0 || sel >= 80) begin
			if (sel >= 95) return '0;
			return 48'({$urandom, $urandom} & AMASK);
		end
		k = $urandom_range(0, tbl_count[0] - 1);
		off = {$urandom, $urandom} % tbl_len[0][k];
		if (sel < 60) return 48'(tbl_base[0][k] + off);
		if (sel < 70) return 48'(tbl_base[0][k] + tbl_len[0][k] - 1);
		if (sel < 75) return 48'(tbl_base[0][k]);
		return 48'(tbl_base[0][k] + tbl_len[0][k]);
	endfunction

	function automatic logic [39:0] pick_size();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 2) return '0;
		if (sel < 5) return SZMAX[39:0];
		if (sel < 7) return 40'({$urandom, $urandom} & SZMAX);
		if (sel < 20) return 40'($urandom_range(1, 255));
		if (sel < 30) return 40'(256 * $urandom_range(1, 64));
		return 40'($urandom_range(1, 65536));
	endfunction

	task automatic random_requests(input int n);
		int i, w, sel;
		for (i = 0; i < n; i++) begin
			w = ((i / 100) % 2 == 0) ? 75 : 30;
			sel = $urandom_range(0, 99);
			if (sel < w) push_request(ACT_ALLOC, 48'({$urandom, $urandom}), pick_size());
			else if (sel >= 97)
				push_request(ACT_NONE, 48'({$urandom, $urandom}), 40'({$urandom, $urandom}));
			else if ((sel - w) % 2 == 0)
				push_request(ACT_FREE, pick_address(), 40'({$urandom, $urandom}));
			else push_request(ACT_LOOKUP, pick_address(), 40'({$urandom, $urandom}));
		end
	endtask

	always @(posedge clk) begin
		region_result_t e;
		request_t r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
		if (done) begin
			if (expected_q.size() == 0) report_mismatch("result with nothing pending", 0, 0);
			else begin
				e = expected_q.pop_front();
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (region_base !== e.base) report_mismatch("region_base", region_base, e.base);
				if (region_offset !== e.off)
					report_mismatch("region_offset", region_offset, e.off);
				if (region_length !== e.len)
					report_mismatch("region_length", region_length, e.len);
				if (regions_in_use !== e.cnt)
					report_mismatch("regions_in_use", regions_in_use, e.cnt);
			end
		end
		taken = start && !busy;
		if (taken) begin
			r.act = action_t'(action); r.addr = address; r.size = byte_size;
			predict_region_op(1, r, e);
			expected_q.push_back(e);
			requests++;
			if (r.act == ACT_ALLOC) begin
				if (e.st == ST_OK) n_alloc++;
				if (e.st == ST_FULL) n_full++;
				if (e.st == ST_EXHAUSTED) n_exh++;
			end
			if (r.act == ACT_FREE && e.len != 0) n_free++;
			if (r.act == ACT_LOOKUP && e.st == ST_OK) n_hit++;
		end
	end

	always @(negedge clk) begin
		request_t r;
		if ($urandom_range(0, 199) == 0) quiet <= !quiet;
		if (start && !taken) begin
			// hold the request until it is taken
		end else if (gap_left > 0) begin
			start <= 0;
			gap_left--;
		end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
			start <= 0;
			gap_left = $urandom_range(0, 6);
		end else if (pending_q.size() != 0) begin
			r = pending_q.pop_front();
			start <= 1; action <= r.act; address <= r.addr; byte_size <= r.size;
		end else start <= 0;
	end

	initial begin
		logic [63:0] rd;
		arst_n = 0; start = 0; action = ACT_NONE; address = '0; byte_size = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		for (int s = 0; s < 2; s++) begin
			tbl_start[s] = DEFAULT_START & AMASK; tbl_next[s] = 0; tbl_count[s] = 0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1;
		apb_access(REG_UNUSED, 1'b1, {$urandom, $urandom}, rd);
		write_start(64'hFFFF_FFFF_FFFF_FFFF);
		push_request(ACT_ALLOC, '0, 40'd1);
		push_request(ACT_ALLOC, '1, SZMAX[39:0]);
		push_request(ACT_ALLOC, '1, '0);
		push_request(ACT_FREE, '0, '1);
		push_request(ACT_LOOKUP, '0, '0);
		push_request(ACT_FREE, 48'd5, '0);
		push_request(ACT_NONE, '1, '1);
		wait_idle();
		// upper bits are dropped, so the register ends up zero
		write_start(64'hABCD_0000_0000_0000);
		push_request(ACT_ALLOC, '0, 40'd1);
		push_request(ACT_ALLOC, '0, 40'd256);
		push_request(ACT_ALLOC, '0, 40'd257);
		push_request(ACT_ALLOC, '0, SZMAX[39:0]);
		push_request(ACT_LOOKUP, 48'h10_0000, '0);
		push_request(ACT_LOOKUP, 48'h10_0001, '0);
		push_request(ACT_LOOKUP, 48'h10_0300, '0);
		push_request(ACT_LOOKUP, 48'(64'h10_0400 + SZMAX - 1), '0);
		push_request(ACT_LOOKUP, 48'(64'h10_0400 + SZMAX), '0);
		push_request(ACT_LOOKUP, '1, '0);
		push_request(ACT_FREE, 48'h10_01FF, '0);
		push_request(ACT_LOOKUP, 48'h10_0100, '0);
		push_request(ACT_FREE, 48'h10_0100, '0);
		push_request(ACT_FREE, '0, '0);
		push_request(ACT_ALLOC, '0, '0);
		push_request(ACT_ALLOC, '0, 40'd5);
		wait_idle();
		random_requests(400);
		wait_idle();
		random_requests(400);
		wait_idle();
		write_start(64'd1);
		random_requests(800);
		wait_idle();
		write_start(AMASK);
		calm = 1;
		random_requests(300);
		wait_idle();
		repeat (20) @(posedge clk);
		$display("Covered %0d requests: %0d allocations, %0d full, %0d exhausted,",
			requests, n_alloc, n_full, n_exh);
		$display("  %0d regions freed, %0d lookups hit, %0d mismatches", n_free, n_hit, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
